>>> rtl/rrts_pkg.sv
// Shared types and constants for the round-robin task scheduler.
package rrts_pkg;

  localparam int SLOTS_DEF  = 4;
  localparam int CMD_W      = 2;
  localparam int ENTRY_W    = 17;
  localparam int OUT_SLOT_W = 2;
  localparam int STATUS_W   = 2;

  typedef enum logic [CMD_W-1:0] {
    CMD_CREATE    = 2'd0,
    CMD_YIELD     = 2'd1,
    CMD_TERMINATE = 2'd2,
    CMD_START     = 2'd3
  } cmd_e;

  typedef enum logic [1:0] {
    SLOT_DEAD    = 2'd0,
    SLOT_READY   = 2'd1,
    SLOT_RUNNING = 2'd2
  } slot_e;

  typedef enum logic [STATUS_W-1:0] {
    STAT_DONE    = 2'd0,
    STAT_IGNORED = 2'd1,
    STAT_NOTASK  = 2'd2
  } stat_e;

  typedef struct packed {
    logic [CMD_W-1:0]   command;
    logic [ENTRY_W-1:0] entry_address;
  } in_beat_t;

  typedef struct packed {
    logic [OUT_SLOT_W-1:0] running_slot;
    logic [ENTRY_W-1:0]    running_entry;
    logic                  running_valid;
    logic [STATUS_W-1:0]   status;
  } out_beat_t;

  // controller -> datapath
  typedef struct packed {
    logic  latch_in;
    logic  do_create;
    logic  retire;
    logic  activate;
    logic  scan_init;
    logic  scan_step;
    logic  take;
    logic  set_status;
    stat_e status;
    logic  load_out;
  } ctrl_cmd_t;

  // datapath -> controller
  typedef struct packed {
    cmd_e cmd;
    logic active;
    logic can_create;
    logic any_created;
    logic scan_hit;
    logic scan_last;
    logic out_busy;
  } dp_stat_t;

endpackage

>>> rtl/rrts_ctrl.sv
// Controller state machine sequencing command execution and the dispatch scan.
module rrts_ctrl import rrts_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_stall,
  input  dp_stat_t  stat,
  output ctrl_cmd_t cmd
);

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_EXEC = 4'b0010,
    S_SCAN = 4'b0100,
    S_DONE = 4'b1000
  } state_t;

  state_t state_r, state_nxt;

  assign in_stall = (state_r != S_IDLE);

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    cmd.status = STAT_DONE;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.latch_in = 1'b1;
          state_nxt    = S_EXEC;
        end
      end
      S_EXEC: begin
        unique case (stat.cmd) inside
          CMD_CREATE: begin
            cmd.set_status = 1'b1;
            if (stat.can_create) begin
              cmd.do_create = 1'b1;
              cmd.status    = STAT_DONE;
            end else begin
              cmd.status = STAT_IGNORED;
            end
            state_nxt = S_DONE;
          end
          CMD_YIELD, CMD_TERMINATE: begin
            if (stat.active) begin
              cmd.retire    = 1'b1;
              cmd.scan_init = 1'b1;
              state_nxt     = S_SCAN;
            end else begin
              cmd.set_status = 1'b1;
              cmd.status     = STAT_IGNORED;
              state_nxt      = S_DONE;
            end
          end
          default: begin
            if (!stat.active && stat.any_created) begin
              cmd.activate  = 1'b1;
              cmd.scan_init = 1'b1;
              state_nxt     = S_SCAN;
            end else begin
              cmd.set_status = 1'b1;
              cmd.status     = STAT_IGNORED;
              state_nxt      = S_DONE;
            end
          end
        endcase
      end
      S_SCAN: begin
        if (stat.scan_hit) begin
          cmd.take       = 1'b1;
          cmd.set_status = 1'b1;
          cmd.status     = STAT_DONE;
          state_nxt      = S_DONE;
        end else if (stat.scan_last) begin
          cmd.set_status = 1'b1;
          cmd.status     = STAT_NOTASK;
          state_nxt      = S_DONE;
        end else begin
          cmd.scan_step = 1'b1;
        end
      end
      S_DONE: begin
        if (!stat.out_busy) begin
          cmd.load_out = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

>>> rtl/rrts_dpath.sv
// Datapath: slot table, indices, created count, scan pointer and result register.
module rrts_dpath import rrts_pkg::*; #(
  parameter int SLOTS = SLOTS_DEF
) (
  input  logic      clk,
  input  logic      rst_n,
  input  in_beat_t  in_data,
  input  logic      out_stall,
  output logic      out_valid,
  output out_beat_t out_data,
  input  ctrl_cmd_t cmd,
  output dp_stat_t  stat
);

  localparam int IDX_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int CNT_W = $clog2(SLOTS + 1);

  slot_e              slot_state_r [SLOTS];
  logic [ENTRY_W-1:0] slot_entry_r [SLOTS];
  logic [IDX_W-1:0]   scan_idx_r;
  logic [IDX_W-1:0]   cur_idx_r;
  logic [CNT_W-1:0]   cnt_r;
  logic               active_r;
  cmd_e               cmd_r;
  logic [ENTRY_W-1:0] entry_r;
  logic [IDX_W-1:0]   ptr_r;
  logic [IDX_W-1:0]   step_r;
  stat_e              status_r;
  out_beat_t          out_r;
  logic               out_valid_r;

  logic [IDX_W-1:0]   free_idx;
  logic               free_found;
  logic               task_runs;
  logic [IDX_W-1:0]   ptr_inc;

  always_comb begin
    free_idx   = '0;
    free_found = 1'b0;
    for (int i = SLOTS - 1; i >= 0; i--) begin
      if (slot_state_r[i] == SLOT_DEAD) begin
        free_idx   = IDX_W'(i);
        free_found = 1'b1;
      end
    end
  end

  assign task_runs = active_r && (slot_state_r[cur_idx_r] == SLOT_RUNNING);
  assign ptr_inc   = (ptr_r == IDX_W'(SLOTS - 1)) ? '0 : ptr_r + 1'b1;

  assign stat.cmd        = cmd_r;
  assign stat.active     = active_r;
  assign stat.can_create = (cnt_r < CNT_W'(SLOTS)) && free_found;
  assign stat.any_created = (cnt_r != '0);
  assign stat.scan_hit   = (slot_state_r[ptr_r] == SLOT_READY);
  assign stat.scan_last  = (step_r == IDX_W'(SLOTS - 1));
  assign stat.out_busy   = out_valid_r && out_stall;

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < SLOTS; i++) begin
        slot_state_r[i] <= SLOT_DEAD;
      end
      scan_idx_r  <= '0;
      cur_idx_r   <= '0;
      cnt_r       <= '0;
      active_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (cmd.do_create) begin
        slot_state_r[free_idx] <= SLOT_READY;
        cnt_r                  <= cnt_r + 1'b1;
      end
      if (cmd.retire && task_runs) begin
        slot_state_r[cur_idx_r] <= (cmd_r == CMD_YIELD) ? SLOT_READY : SLOT_DEAD;
      end
      if (cmd.activate) begin
        active_r <= 1'b1;
      end
      if (cmd.take) begin
        slot_state_r[ptr_r] <= SLOT_RUNNING;
        cur_idx_r           <= ptr_r;
        scan_idx_r          <= ptr_inc;
      end
      if (cmd.load_out) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.latch_in) begin
      cmd_r   <= cmd_e'(in_data.command);
      entry_r <= in_data.entry_address;
    end
    if (cmd.do_create) begin
      slot_entry_r[free_idx] <= entry_r;
    end
    if (cmd.scan_init) begin
      ptr_r  <= scan_idx_r;
      step_r <= '0;
    end else if (cmd.scan_step) begin
      ptr_r  <= ptr_inc;
      step_r <= step_r + 1'b1;
    end
    if (cmd.set_status) begin
      status_r <= cmd.status;
    end
    if (cmd.load_out) begin
      out_r.status <= status_r;
      if (task_runs) begin
        out_r.running_slot  <= OUT_SLOT_W'(cur_idx_r);
        out_r.running_entry <= slot_entry_r[cur_idx_r];
        out_r.running_valid <= 1'b1;
      end else begin
        out_r.running_slot  <= '0;
        out_r.running_entry <= '0;
        out_r.running_valid <= 1'b0;
      end
    end
  end

endmodule

>>> rtl/round_robin_task_scheduler.sv
// A create or an ignored command goes from S_EXEC straight to S_DONE; a dispatch passes
// through S_SCAN on the way, one slot checked per cycle by the scan.
// Commands are handled one at a time; the next input beat is taken the cycle after the
// result is loaded; a held result does not block that beat, but the next result waits for it.
// Reset (rst_n low, synchronous): all slots dead, indices and count zero, kernel stopped,
// no result pending.
module round_robin_task_scheduler import rrts_pkg::*; #(
  parameter int SLOTS = SLOTS_DEF
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_stall,
  input  in_beat_t  in_data,
  output logic      out_valid,
  input  logic      out_stall,
  output out_beat_t out_data
);

  ctrl_cmd_t cmd;
  dp_stat_t  stat;

  rrts_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .stat     (stat),
    .cmd      (cmd)
  );

  rrts_dpath #(
    .SLOTS (SLOTS)
  ) u_dpath (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_data   (in_data),
    .out_stall (out_stall),
    .out_valid (out_valid),
    .out_data  (out_data),
    .cmd       (cmd),
    .stat      (stat)
  );

endmodule

>>> rtl/rrts_chk.sv
// Port-level checker for the round-robin task scheduler, bound to the top level.
module rrts_chk import rrts_pkg::*; (
  input logic      clk,
  input logic      rst_n,
  input logic      in_valid,
  input logic      in_stall,
  input in_beat_t  in_data,
  input logic      out_valid,
  input logic      out_stall,
  input out_beat_t out_data
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("result beat changed while stalled");

  a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall)
    else $error("second command taken while one is in flight");

  a_idle_no_task: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_data.status == STAT_NOTASK) |-> !out_data.running_valid)
    else $error("idle status reported with a running task");

  a_zero_when_none: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_data.running_valid |->
      (out_data.running_slot == '0) && (out_data.running_entry == '0))
    else $error("slot or entry nonzero with no running task");

  a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_data.status == STAT_DONE) || (out_data.status == STAT_IGNORED) ||
                  (out_data.status == STAT_NOTASK))
    else $error("undefined status code");

endmodule

bind round_robin_task_scheduler rrts_chk u_rrts_chk (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_stall  (in_stall),
  .in_data   (in_data),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_data  (out_data)
);

>>> tb/round_robin_task_scheduler_tb.sv
// Self-checking testbench for the round-robin task scheduler with random handshake gaps.
module round_robin_task_scheduler_tb import rrts_pkg::*;;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int SLOTS = SLOTS_DEF;

  logic      clk = 1'b0;
  logic      rst_n = 1'b0;
  logic      in_valid = 1'b0;
  logic      in_stall;
  in_beat_t  in_data = '0;
  logic      out_valid;
  logic      out_stall = 1'b0;
  out_beat_t out_data;

  round_robin_task_scheduler #(.SLOTS(SLOTS)) dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data (out_data)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  initial begin
    #5_000_000;
    $display("TB_ERROR");
    $finish;
  end

  // scheduler state mirror
  slot_e              slot_st  [SLOTS];
  logic [ENTRY_W-1:0] slot_ent [SLOTS];
  int unsigned        next_scan;
  int unsigned        cur_slot;
  int unsigned        created;
  bit                 sched_live;

  out_beat_t   due_results[$];
  int unsigned err_count = 0;
  bit          quiet = 1'b0;
  int unsigned stall_left = 0;

  function automatic bit task_running();
    return sched_live && slot_st[cur_slot] == SLOT_RUNNING;
  endfunction

  function automatic bit dispatch_next();
    int unsigned idx;
    bit          hit;
    idx = next_scan % SLOTS;
    hit = 1'b0;
    for (int k = 0; k < SLOTS; k++) begin
      if (!hit && slot_st[idx] == SLOT_READY) begin
        slot_st[idx] = SLOT_RUNNING;
        cur_slot     = idx;
        next_scan    = (idx + 1) % SLOTS;
        hit          = 1'b1;
      end
      idx = (idx + 1) % SLOTS;
    end
    return hit;
  endfunction

  function automatic out_beat_t schedule_cmd(in_beat_t b);
    cmd_e      c;
    stat_e     st;
    out_beat_t r;
    bit        placed;
    c      = cmd_e'(b.command);
    st     = STAT_IGNORED;
    placed = 1'b0;
    case (c)
      CMD_CREATE: begin
        if (created < SLOTS) begin
          for (int i = 0; i < SLOTS; i++) begin
            if (!placed && slot_st[i] == SLOT_DEAD) begin
              slot_st[i]  = SLOT_READY;
              slot_ent[i] = b.entry_address;
              created++;
              placed = 1'b1;
              st     = STAT_DONE;
            end
          end
        end
      end
      CMD_YIELD, CMD_TERMINATE: begin
        if (sched_live) begin
          if (task_running())
            slot_st[cur_slot] = (c == CMD_YIELD) ? SLOT_READY : SLOT_DEAD;
          st = dispatch_next() ? STAT_DONE : STAT_NOTASK;
        end
      end
      CMD_START: begin
        if (!sched_live && created > 0) begin
          sched_live = 1'b1;
          st = dispatch_next() ? STAT_DONE : STAT_NOTASK;
        end
      end
      default: st = STAT_IGNORED;
    endcase
    r = '0;
    if (task_running()) begin
      r.running_slot  = cur_slot[OUT_SLOT_W-1:0];
      r.running_entry = slot_ent[cur_slot];
      r.running_valid = 1'b1;
    end
    r.status = st;
    return r;
  endfunction

  task automatic report_mismatch(string msg);
    $display("mismatch @%0t: %s", $realtime, msg);
    err_count++;
  endtask

  always @(posedge clk) begin : check_results
    out_beat_t want;
    if (rst_n) begin
      if (in_valid && !in_stall)
        due_results.push_back(schedule_cmd(in_data));
      if (out_valid && !out_stall) begin
        if (due_results.size() == 0) begin
          report_mismatch($sformatf("unexpected beat %h", out_data));
        end else begin
          want = due_results.pop_front();
          if (out_data.running_slot !== want.running_slot)
            report_mismatch($sformatf("running_slot %0d, want %0d",
                                      out_data.running_slot, want.running_slot));
          if (out_data.running_entry !== want.running_entry)
            report_mismatch($sformatf("running_entry %h, want %h",
                                      out_data.running_entry, want.running_entry));
          if (out_data.running_valid !== want.running_valid)
            report_mismatch($sformatf("running_valid %b, want %b",
                                      out_data.running_valid, want.running_valid));
          if (out_data.status !== want.status)
            report_mismatch($sformatf("status %0d, want %0d",
                                      out_data.status, want.status));
        end
      end
    end
  end

  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 40) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  // receiver back-pressure
  always @(negedge clk) begin
    if (stall_left == 0) begin
      out_stall <= 1'b0;
      if (rst_n && !quiet && $urandom_range(0, 99) < 30)
        stall_left = pick_gap();
    end else begin
      out_stall <= 1'b1;
      stall_left--;
    end
  end

  function automatic logic [ENTRY_W-1:0] rand_entry();
    return ENTRY_W'($urandom_range(0, (1 << ENTRY_W) - 1));
  endfunction

  // entered and left at a falling edge; valid stays up for a back-to-back beat
  task automatic send_cmd(cmd_e c, logic [ENTRY_W-1:0] e);
    int unsigned g;
    g = quiet ? 0 : pick_gap();
    if (g > 0) begin
      in_valid <= 1'b0;
      repeat (g) @(negedge clk);
    end
    in_valid              <= 1'b1;
    in_data.command       <= c;
    in_data.entry_address <= e;
    do @(posedge clk); while (in_stall);
    @(negedge clk);
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    while (due_results.size() != 0) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic test_before_start();
    send_cmd(CMD_YIELD, rand_entry());
    send_cmd(CMD_TERMINATE, rand_entry());
    send_cmd(CMD_START, rand_entry());
    send_cmd(CMD_CREATE, {ENTRY_W{1'b1}});
  endtask

  task automatic test_start();
    send_cmd(CMD_START, rand_entry());
    send_cmd(CMD_START, rand_entry());
  endtask

  task automatic test_create_while_running();
    send_cmd(CMD_CREATE, '0);
    send_cmd(CMD_YIELD, rand_entry());
    send_cmd(CMD_CREATE, rand_entry());
    send_cmd(CMD_CREATE, rand_entry());
    send_cmd(CMD_CREATE, rand_entry());
  endtask

  task automatic test_count_never_falls();
    send_cmd(CMD_TERMINATE, rand_entry());
    send_cmd(CMD_CREATE, rand_entry());
    send_cmd(CMD_YIELD, '0);
    send_cmd(CMD_YIELD, {ENTRY_W{1'b1}});
  endtask

  task automatic test_random_mix(int unsigned n);
    int unsigned r;
    cmd_e        c;
    for (int unsigned i = 0; i < n; i++) begin
      if (i % 50 == 0)
        quiet = ($urandom_range(0, 3) == 0);
      if (i == n / 2)
        wait_drained();
      r = $urandom_range(0, 999);
      if (r < 6)        c = CMD_TERMINATE;
      else if (r < 800) c = CMD_YIELD;
      else if (r < 900) c = CMD_CREATE;
      else              c = CMD_START;
      send_cmd(c, rand_entry());
    end
    quiet = 1'b0;
  endtask

  task automatic test_wind_down();
    repeat (SLOTS) send_cmd(CMD_TERMINATE, rand_entry());
    send_cmd(CMD_YIELD, rand_entry());
    send_cmd(CMD_TERMINATE, rand_entry());
    send_cmd(CMD_START, rand_entry());
    send_cmd(CMD_CREATE, rand_entry());
  endtask

  initial begin
    for (int i = 0; i < SLOTS; i++) begin
      slot_st[i]  = SLOT_DEAD;
      slot_ent[i] = '0;
    end
    next_scan  = 0;
    cur_slot   = 0;
    created    = 0;
    sched_live = 1'b0;

    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    test_before_start();
    test_start();
    test_create_while_running();
    test_count_never_falls();
    wait_drained();
    test_random_mix(530);
    test_wind_down();

    wait_drained();
    quiet = 1'b1;
    repeat (SLOTS + 8) @(posedge clk);
    if (err_count == 0)
      $display("TB_OK");
    else
      $display("TB_ERROR");
    $finish;
  end

endmodule
